FILE: hdl/qmsc_pkg.sv
// shared types, codes and the encoder transition table for the move controller
package qmsc_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TICK   = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        T_NONE = 2'd0,
        T_CW   = 2'd1,
        T_CCW  = 2'd2,
        T_BAD  = 2'd3
    } trans_t;

    typedef enum logic [1:0] {
        LIM_NONE    = 2'd0,
        LIM_CLEARED = 2'd1,
        LIM_HIT     = 2'd2
    } lim_t;

    localparam logic [1:0] PIN_LOW  = 2'd0;
    localparam logic [1:0] PIN_HIGH = 2'd1;
    localparam logic [1:0] PIN_PWM  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENCODER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_DRIVE      = 1'b1;

    // classify one encoder move from the previous phase to the current one
    function automatic trans_t trans_lookup(input logic [1:0] prev, input logic [1:0] cur);
        trans_t t;
        begin
            case ({prev, cur})
                4'b00_00: t = T_NONE;
                4'b00_01: t = T_CW;
                4'b00_10: t = T_CCW;
                4'b00_11: t = T_BAD;
                4'b01_00: t = T_CCW;
                4'b01_01: t = T_NONE;
                4'b01_10: t = T_BAD;
                4'b01_11: t = T_CW;
                4'b10_00: t = T_CW;
                4'b10_01: t = T_BAD;
                4'b10_10: t = T_NONE;
                4'b10_11: t = T_CCW;
                4'b11_00: t = T_BAD;
                4'b11_01: t = T_CCW;
                4'b11_10: t = T_CW;
                4'b11_11: t = T_NONE;
                default:  t = T_BAD;
            endcase
            return t;
        end
    endfunction

endpackage

FILE: hdl/quadrature_move_stall_controller.sv
// quadrature move and stall controller: input register, state update, result register
//
// Every input word (start, encoder sample, ms tick, stop) yields exactly one result word.
// One word is accepted per clock when the result side keeps up; an accepted word sits in
// the input register, then moves through the state update into the result register once
// that register is empty or being taken, and is held there until the result side takes it.
// The single state update between the two registers is what sets that rate: the
// drift-limited step command, the transition table lookup and the 16-bit step and
// watchdog compares all resolve combinationally in it. Position drift against the target is
// kept as a pair of difference registers so a start needs no subtract of position and target.
// Configuration writes are always ready and should only be issued while the block is idle.
module quadrature_move_stall_controller #(
    parameter int STEPS_PER_MOVE = 8,
    parameter int POS_BITS       = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [1:0]                       move_dir,
    input  logic [1:0]                       phase_bits,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       pin1_drive,
    output logic [1:0]                       pin2_drive,
    output logic                             moving,
    output logic [1:0]                       limit_event,
    output logic signed [15:0]               step_count,
    output logic signed [31:0]               position,
    output logic [15:0]                      illegal_count,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qmsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data
);

    localparam int PW = (POS_BITS > 32) ? POS_BITS : 32;
    localparam logic [15:0]         SPM16     = 16'(STEPS_PER_MOVE);
    localparam logic [POS_BITS-1:0] SPM_POS   = POS_BITS'(STEPS_PER_MOVE);
    localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);
    localparam logic [PW-1:0]       FLOOR_MAG = PW'(STEPS_PER_MOVE + 32768);

    // configuration
    logic invert_reg;
    logic pwm_reg;

    // input register
    logic              q_valid_reg;
    qmsc_pkg::op_t     q_op_reg;
    logic [1:0]        q_dir_reg;
    logic [1:0]        q_phase_reg;

    // block state
    logic [1:0]           last_phase_reg,  last_phase_next;
    logic [15:0]          steps_done_reg,  steps_done_next;
    logic [15:0]          steps_target_reg, steps_target_next;
    logic [POS_BITS-1:0]  actual_pos_reg,  actual_pos_next;
    logic [POS_BITS-1:0]  delta_reg,       delta_next;     // actual - target
    logic [POS_BITS-1:0]  ndelta_reg,      ndelta_next;    // target - actual
    logic [15:0]          bad_reg,         bad_next;
    logic                 armed_reg,       armed_next;
    logic [15:0]          wlc_reg,         wlc_next;
    logic                 driving_reg,     driving_next;
    qmsc_pkg::dir_t       drive_dir_reg,   drive_dir_next;

    // result register
    logic                 out_valid_reg;
    logic [1:0]           pin1_reg, pin2_reg;
    logic                 moving_reg;
    qmsc_pkg::lim_t       limit_reg, limit_next;
    logic [15:0]          step_count_reg;
    logic [31:0]          position_reg;
    logic [15:0]          illegal_reg;

    logic                 adv;
    logic                 in_accept;
    qmsc_pkg::dir_t       start_dir;
    qmsc_pkg::trans_t     trans;
    logic [POS_BITS-1:0]  drift;
    logic [POS_BITS-1:0]  drift_mag;
    logic [15:0]          command;
    logic                 step_up;
    logic [15:0]          steps_stepped;
    logic [1:0]           pin1_next, pin2_next;
    logic [PW-1:0]        pos_wide;

    assign adv       = q_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = q_valid_reg && !adv;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (q_dir_reg)
            2'(qmsc_pkg::DIR_CW):  start_dir = qmsc_pkg::DIR_CW;
            2'(qmsc_pkg::DIR_CCW): start_dir = qmsc_pkg::DIR_CCW;
            default:               start_dir = qmsc_pkg::DIR_STOP;
        endcase
    end

    // step command: nominal move plus drift toward the target, drift capped, floor saturated
    always_comb
    begin
        case (start_dir)
            qmsc_pkg::DIR_CW:
            begin
                drift     = ndelta_reg;
                drift_mag = delta_reg;
            end
            qmsc_pkg::DIR_CCW:
            begin
                drift     = delta_reg;
                drift_mag = ndelta_reg;
            end
            default:
            begin
                drift     = '0;
                drift_mag = '0;
            end
        endcase
        if (drift[POS_BITS-1])
        begin
            if (PW'(drift_mag) >= FLOOR_MAG)
                command = 16'h8000;
            else
                command = SPM16 - drift_mag[15:0];
        end
        else if (drift > SPM_POS)
        begin
            command = SPM16 + SPM16;
        end
        else
        begin
            command = SPM16 + drift[15:0];
        end
    end

    assign trans         = qmsc_pkg::trans_lookup(last_phase_reg, q_phase_reg);
    assign step_up       = (2'(trans) == 2'(drive_dir_reg)) ^ invert_reg;
    assign steps_stepped = step_up ? steps_done_reg + 16'd1 : steps_done_reg - 16'd1;

    always_comb
    begin
        last_phase_next   = last_phase_reg;
        steps_done_next   = steps_done_reg;
        steps_target_next = steps_target_reg;
        actual_pos_next   = actual_pos_reg;
        delta_next        = delta_reg;
        ndelta_next       = ndelta_reg;
        bad_next          = bad_reg;
        armed_next        = armed_reg;
        wlc_next          = wlc_reg;
        driving_next      = driving_reg;
        drive_dir_next    = drive_dir_reg;
        limit_next        = qmsc_pkg::LIM_NONE;
        case (q_op_reg)
            qmsc_pkg::OP_START:
            begin
                steps_target_next = command;
                steps_done_next   = '0;
                bad_next          = '0;
                wlc_next          = '0;
                armed_next        = 1'b0;
                driving_next      = 1'b1;
                drive_dir_next    = start_dir;
                if (start_dir == qmsc_pkg::DIR_CW)
                begin
                    delta_next  = delta_reg - SPM_POS;
                    ndelta_next = ndelta_reg + SPM_POS;
                end
                else if (start_dir == qmsc_pkg::DIR_CCW)
                begin
                    delta_next  = delta_reg + SPM_POS;
                    ndelta_next = ndelta_reg - SPM_POS;
                end
            end
            qmsc_pkg::OP_SAMPLE:
            begin
                last_phase_next = q_phase_reg;
                if (trans == qmsc_pkg::T_BAD)
                begin
                    bad_next = bad_reg + 16'd1;
                end
                else if (trans != qmsc_pkg::T_NONE)
                begin
                    steps_done_next = steps_stepped;
                    if ((trans == qmsc_pkg::T_CW) != invert_reg)
                    begin
                        actual_pos_next = actual_pos_reg + POS_ONE;
                        delta_next      = delta_reg + POS_ONE;
                        ndelta_next     = ndelta_reg - POS_ONE;
                    end
                    else
                    begin
                        actual_pos_next = actual_pos_reg - POS_ONE;
                        delta_next      = delta_reg - POS_ONE;
                        ndelta_next     = ndelta_reg + POS_ONE;
                    end
                    if (($signed(steps_stepped) > 16'sd0) && !armed_reg)
                    begin
                        armed_next = 1'b1;
                        limit_next = qmsc_pkg::LIM_CLEARED;
                    end
                    // target reached: brake
                    if (driving_reg && ($signed(steps_stepped) >= $signed(steps_target_reg)))
                    begin
                        driving_next   = 1'b0;
                        drive_dir_next = qmsc_pkg::DIR_STOP;
                        armed_next     = 1'b0;
                    end
                end
            end
            qmsc_pkg::OP_TICK:
            begin
                if (driving_reg)
                begin
                    // no progress since last tick on an armed move means stall
                    if ((steps_done_reg == wlc_reg) && armed_reg)
                    begin
                        driving_next   = 1'b0;
                        drive_dir_next = qmsc_pkg::DIR_STOP;
                        armed_next     = 1'b0;
                        limit_next     = qmsc_pkg::LIM_HIT;
                    end
                    else
                    begin
                        wlc_next = steps_done_reg;
                    end
                end
            end
            qmsc_pkg::OP_STOP:
            begin
                driving_next   = 1'b0;
                drive_dir_next = qmsc_pkg::DIR_STOP;
            end
            default:
            begin
                driving_next = driving_reg;
            end
        endcase
    end

    always_comb
    begin
        if (pwm_reg)
        begin
            pin1_next = (drive_dir_next == qmsc_pkg::DIR_CCW) ? qmsc_pkg::PIN_PWM
                                                              : qmsc_pkg::PIN_HIGH;
            pin2_next = (drive_dir_next == qmsc_pkg::DIR_CW)  ? qmsc_pkg::PIN_PWM
                                                              : qmsc_pkg::PIN_HIGH;
        end
        else
        begin
            pin1_next = (drive_dir_next == qmsc_pkg::DIR_CW)  ? qmsc_pkg::PIN_HIGH
                                                              : qmsc_pkg::PIN_LOW;
            pin2_next = (drive_dir_next == qmsc_pkg::DIR_CCW) ? qmsc_pkg::PIN_HIGH
                                                              : qmsc_pkg::PIN_LOW;
        end
    end

    assign pos_wide = PW'(actual_pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
            pwm_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qmsc_pkg::CFG_INVERT_ENCODER: invert_reg <= cfg_data;
                qmsc_pkg::CFG_PWM_DRIVE:      pwm_reg    <= cfg_data;
                default:                      pwm_reg    <= pwm_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                q_valid_reg <= 1'b1;
            else if (adv)
                q_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            q_op_reg    <= qmsc_pkg::op_t'(opcode);
            q_dir_reg   <= move_dir;
            q_phase_reg <= phase_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg   <= '0;
            steps_done_reg   <= '0;
            steps_target_reg <= '0;
            actual_pos_reg   <= '0;
            delta_reg        <= '0;
            ndelta_reg       <= '0;
            bad_reg          <= '0;
            armed_reg        <= 1'b0;
            wlc_reg          <= '0;
            driving_reg      <= 1'b0;
            drive_dir_reg    <= qmsc_pkg::DIR_STOP;
        end
        else if (adv)
        begin
            last_phase_reg   <= last_phase_next;
            steps_done_reg   <= steps_done_next;
            steps_target_reg <= steps_target_next;
            actual_pos_reg   <= actual_pos_next;
            delta_reg        <= delta_next;
            ndelta_reg       <= ndelta_next;
            bad_reg          <= bad_next;
            armed_reg        <= armed_next;
            wlc_reg          <= wlc_next;
            driving_reg      <= driving_next;
            drive_dir_reg    <= drive_dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pin1_reg       <= pin1_next;
            pin2_reg       <= pin2_next;
            moving_reg     <= driving_next;
            limit_reg      <= limit_next;
            step_count_reg <= steps_done_next;
            position_reg   <= pos_wide[31:0];
            illegal_reg    <= bad_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pin1_drive    = pin1_reg;
    assign pin2_drive    = pin2_reg;
    assign moving        = moving_reg;
    assign limit_event   = limit_reg;
    assign step_count    = $signed(step_count_reg);
    assign position      = $signed(position_reg);
    assign illegal_count = illegal_reg;

    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (q_op_reg == qmsc_pkg::OP_STOP) |=> !driving_reg && !moving_reg)
        else $error("stop word left the motor driving");

    a_hit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (limit_next == qmsc_pkg::LIM_HIT) |=> !driving_reg && !armed_reg)
        else $error("limit hit without halting the move");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && out_valid_reg && out_stall |=> q_valid_reg && $stable(q_op_reg))
        else $error("pending word dropped while result stalled");

    a_idle_dir_stop: assert property (@(posedge clk) disable iff (!rst_n)
        !driving_reg |-> (drive_dir_reg == qmsc_pkg::DIR_STOP))
        else $error("idle with a drive direction set");

endmodule

FILE: sim/tb_quadrature_move_stall_controller.sv
// testbench for the quadrature move controller: random and directed words against a predictor
module tb_quadrature_move_stall_controller;
    import qmsc_pkg::*;

    localparam int MOVE_STEPS   = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SWEEP_STARTS = 100;
    localparam int PHASE_WORDS  = 215;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [1:0]  pin1;
        logic [1:0]  pin2;
        logic        run;
        logic [1:0]  limit;
        logic [15:0] steps;
        logic [31:0] pos;
        logic [15:0] bad;
    } drive_word_t;

    class motion_scoreboard;
        bit          invert_sense;
        bit          slow_decay;
        logic [1:0]  prev_phase;
        logic [15:0] step_cnt;
        logic [15:0] step_cmd;
        logic [15:0] bad_cnt;
        logic [15:0] watch_snap;
        logic [31:0] cur_pos;
        logic [31:0] goal_pos;
        bit          armed;
        bit          running;
        dir_t        heading;
        drive_word_t words_due[$];
        int          mismatches;
        int          compared;
        int          limit_hits;
        int          limit_clears;
        int          brakes;

        function new();
            invert_sense = 1'b0;
            slow_decay   = 1'b1;
            prev_phase   = 2'b00;
            step_cnt     = '0;
            step_cmd     = '0;
            bad_cnt      = '0;
            watch_snap   = '0;
            cur_pos      = '0;
            goal_pos     = '0;
            armed        = 1'b0;
            running      = 1'b0;
            heading      = DIR_STOP;
            mismatches   = 0;
            compared     = 0;
            limit_hits   = 0;
            limit_clears = 0;
            brakes       = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == CFG_INVERT_ENCODER)
                invert_sense = val;
            else if (idx == CFG_PWM_DRIVE)
                slow_decay = val;
        endfunction

        // step command: nominal count plus drift, drift capped above, command floored below
        function logic [15:0] move_command(logic [31:0] drift);
            logic [31:0] mag;
            int          cmd;
            if (drift[31])
            begin
                mag = -drift;
                if (mag >= 32'(MOVE_STEPS + 32768))
                    cmd = -32768;
                else
                    cmd = MOVE_STEPS - int'(mag);
            end
            else if (drift > 32'(MOVE_STEPS))
                cmd = 2 * MOVE_STEPS;
            else
                cmd = MOVE_STEPS + int'(drift);
            return cmd[15:0];
        endfunction

        // gray index distance around the cycle 00 01 11 10
        function trans_t classify(logic [1:0] prev, logic [1:0] cur);
            logic [1:0] a;
            logic [1:0] b;
            logic [1:0] hop;
            a   = {prev[1], prev[1] ^ prev[0]};
            b   = {cur[1], cur[1] ^ cur[0]};
            hop = b - a;
            case (hop)
                2'd0:    return T_NONE;
                2'd1:    return T_CW;
                2'd2:    return T_BAD;
                default: return T_CCW;
            endcase
        endfunction

        function void halt();
            heading = DIR_STOP;
            running = 1'b0;
        endfunction

        function void note_word(op_t op, logic [1:0] dir_raw, logic [1:0] ph);
            drive_word_t w;
            trans_t      t;
            dir_t        d;
            logic [31:0] drift;
            bit          up;
            lim_t        lim;
            lim = LIM_NONE;
            case (op)
                OP_START:
                begin
                    if (dir_raw == DIR_CW)
                        d = DIR_CW;
                    else if (dir_raw == DIR_CCW)
                        d = DIR_CCW;
                    else
                        d = DIR_STOP;
                    drift = '0;
                    if (d == DIR_CCW)
                        drift = cur_pos - goal_pos;
                    else if (d == DIR_CW)
                        drift = goal_pos - cur_pos;
                    step_cmd   = move_command(drift);
                    step_cnt   = '0;
                    bad_cnt    = '0;
                    watch_snap = '0;
                    armed      = 1'b0;
                    running    = 1'b1;
                    if (d == DIR_CW)
                        goal_pos = goal_pos + 32'(MOVE_STEPS);
                    else if (d == DIR_CCW)
                        goal_pos = goal_pos - 32'(MOVE_STEPS);
                    heading = d;
                end
                OP_SAMPLE:
                begin
                    t = classify(prev_phase, ph);
                    prev_phase = ph;
                    if (t == T_BAD)
                        bad_cnt = bad_cnt + 16'd1;
                    else if (t != T_NONE)
                    begin
                        up = (int'(t) == int'(heading)) ^ invert_sense;
                        step_cnt = up ? step_cnt + 16'd1 : step_cnt - 16'd1;
                        if ((t == T_CW) != invert_sense)
                            cur_pos = cur_pos + 32'd1;
                        else
                            cur_pos = cur_pos - 32'd1;
                        if ($signed(step_cnt) > 0 && !armed)
                        begin
                            armed = 1'b1;
                            lim   = LIM_CLEARED;
                            limit_clears++;
                        end
                        if (running && $signed(step_cnt) >= $signed(step_cmd))
                        begin
                            halt();
                            armed = 1'b0;
                            brakes++;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (running)
                    begin
                        if (step_cnt == watch_snap && armed)
                        begin
                            halt();
                            armed = 1'b0;
                            lim   = LIM_HIT;
                            limit_hits++;
                        end
                        else
                            watch_snap = step_cnt;
                    end
                end
                default:
                    halt();
            endcase

            if (slow_decay)
            begin
                w.pin1 = (heading == DIR_CCW) ? PIN_PWM : PIN_HIGH;
                w.pin2 = (heading == DIR_CW) ? PIN_PWM : PIN_HIGH;
            end
            else
            begin
                w.pin1 = (heading == DIR_CW) ? PIN_HIGH : PIN_LOW;
                w.pin2 = (heading == DIR_CCW) ? PIN_HIGH : PIN_LOW;
            end
            w.run   = running;
            w.limit = lim;
            w.steps = step_cnt;
            w.pos   = cur_pos;
            w.bad   = bad_cnt;
            words_due.push_back(w);
        endfunction

        function void check_word(drive_word_t got);
            drive_word_t want;
            bit          wrong;
            if (words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing expected: steps %0d pos %0d",
                             $signed(got.steps), $signed(got.pos));
                return;
            end
            want = words_due.pop_front();
            compared++;
            wrong = (got.pin1 !== want.pin1) || (got.pin2 !== want.pin2)
                 || (got.run !== want.run) || (got.limit !== want.limit)
                 || (got.steps !== want.steps) || (got.pos !== want.pos)
                 || (got.bad !== want.bad);
            if (wrong)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("word %0d (exp/got): pin1 %0d/%0d pin2 %0d/%0d moving %0b/%0b",
                             compared, want.pin1, got.pin1, want.pin2, got.pin2,
                             want.run, got.run);
                    $display("    limit %0d/%0d steps %0d/%0d pos %0d/%0d illegal %0d/%0d",
                             want.limit, got.limit,
                             $signed(want.steps), $signed(got.steps),
                             $signed(want.pos), $signed(got.pos), want.bad, got.bad);
                end
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           opcode;
    logic [1:0]           move_dir;
    logic [1:0]           phase_bits;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           pin1_drive;
    logic [1:0]           pin2_drive;
    logic                 moving;
    logic [1:0]           limit_event;
    logic signed [15:0]   step_count;
    logic signed [31:0]   position;
    logic [15:0]          illegal_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    motion_scoreboard sb;
    drive_word_t      seen;
    bit               tx_idle;
    bit               rx_idle;
    int               rx_hold;
    int               quiet_cycles;
    int               words_sent;
    int               stall_cycles;
    int               enc_idx;
    logic [1:0]       enc_cycle [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    quadrature_move_stall_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .move_dir      (move_dir),
        .phase_bits    (phase_bits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pin1_drive    (pin1_drive),
        .pin2_drive    (pin2_drive),
        .moving        (moving),
        .limit_event   (limit_event),
        .step_count    (step_count),
        .position      (position),
        .illegal_count (illegal_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(op_t'(opcode), move_dir, phase_bits);
            if (out_valid && !out_stall)
            begin
                seen = '{pin1_drive, pin2_drive, moving, limit_event,
                         step_count, position, illegal_count};
                sb.check_word(seen);
            end
            if (in_valid && in_stall)
                stall_cycles++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("no handshake for %0d cycles, %0d results still due",
                 QUIET_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
    end

    // result side: random stall per word, or one long hold when asked
    initial
    begin
        int wait_n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                wait_n  = rx_hold;
                rx_hold = 0;
            end
            else
                wait_n = rx_idle ? $urandom_range(0, 12) : 0;
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_word(op_t op, logic [1:0] dir, logic [1:0] ph);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        move_dir   <= dir;
        phase_bits <= ph;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // encoder sample moved delta places around the quadrature cycle
    task automatic walk(int delta);
        enc_idx = (enc_idx + delta) & 3;
        send_word(OP_SAMPLE, 2'($urandom), enc_cycle[enc_idx]);
    endtask

    task automatic send_noise();
        op_t        op;
        logic [1:0] ph;
        op = op_t'($urandom_range(0, 3));
        ph = 2'($urandom);
        if (op == OP_SAMPLE)
            enc_idx = int'({ph[1], ph[1] ^ ph[0]});
        send_word(op, 2'($urandom), ph);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic invert, logic pwm);
        settle();
        cfg_write(CFG_INVERT_ENCODER, invert);
        cfg_write(CFG_PWM_DRIVE, pwm);
    endtask

    // one start followed by mostly productive encoder steps, some ticks and faults
    task automatic random_move();
        int         pick;
        int         n;
        int         fwd;
        logic [1:0] dir;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            dir = DIR_CW;
        else if (pick < 8)
            dir = DIR_CCW;
        else if (pick == 8)
            dir = DIR_STOP;
        else
            dir = 2'd3;
        send_word(OP_START, dir, 2'($urandom));
        fwd = (dir == DIR_CCW) ? -1 : 1;
        if (sb.invert_sense)
            fwd = -fwd;
        if (dir != DIR_CW && dir != DIR_CCW && $urandom_range(0, 1))
            fwd = -fwd;
        n = $urandom_range(2, 14);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                walk(fwd);
            else if (pick < 76)
                walk(-fwd);
            else if (pick < 80)
                walk(0);
            else if (pick < 84)
                walk(2);
            else if (pick < 96)
                send_word(OP_TICK, 2'($urandom), 2'($urandom));
            else
                send_word(OP_STOP, 2'($urandom), 2'($urandom));
        end
        // two ticks with no progress between them trip the watchdog
        if ($urandom_range(0, 3) == 0)
        begin
            send_word(OP_TICK, 2'($urandom), 2'($urandom));
            send_word(OP_TICK, 2'($urandom), 2'($urandom));
        end
    endtask

    task automatic run_random(int total);
        int first;
        int mode;
        first = words_sent;
        while (words_sent - first < total)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                mode    = $urandom_range(0, 3);
                tx_idle = (mode == 0) || (mode == 2);
                rx_idle = (mode == 0) || (mode == 3);
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                random_move();
        end
    endtask

    task automatic directed_words();
        send_word(OP_TICK, DIR_CW, 2'b11);
        walk(0);
        send_word(OP_START, DIR_CW, 2'b00);
        walk(1);
        walk(1);
        send_word(OP_TICK, DIR_STOP, 2'b10);
        send_word(OP_TICK, DIR_CCW, 2'b01);
        send_word(OP_START, DIR_CCW, 2'b11);
        walk(-1);
        walk(2);
        walk(1);
        send_word(OP_STOP, 2'd3, 2'b11);
        send_word(OP_START, 2'd3, 2'b00);
        walk(1);
        walk(-1);
        send_word(OP_START, DIR_STOP, 2'b01);
        walk(1);
        send_word(OP_TICK, 2'd3, 2'b00);
        send_word(OP_TICK, DIR_CW, 2'b11);
        send_word(OP_START, DIR_CW, 2'b10);
        repeat (9) walk(1);
    endtask

    // pull the target far from the position so the command goes deep negative, then bring it back
    task automatic command_floor_sweep();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (SWEEP_STARTS) send_word(OP_START, DIR_CCW, 2'($urandom));
        repeat (SWEEP_STARTS) send_word(OP_START, DIR_CW, 2'($urandom));
        walk(1);
        walk(-1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_START;
        move_dir     = DIR_STOP;
        phase_bits   = 2'b00;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_INVERT_ENCODER;
        cfg_data     = 1'b0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold      = 0;
        quiet_cycles = 0;
        words_sent   = 0;
        stall_cycles = 0;
        enc_idx      = 0;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0, 1'b1);
        directed_words();
        command_floor_sweep();

        set_mode(1'b1, 1'b0);
        run_random(PHASE_WORDS);

        set_mode(1'b1, 1'b1);
        tx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        run_random(PHASE_WORDS);

        set_mode(1'b0, 1'b0);
        run_random(PHASE_WORDS);

        set_mode(1'b0, 1'b1);
        run_random(PHASE_WORDS);

        settle();
        repeat (4) @(posedge clk);

        $display("%0d words in over four drive/invert settings, %0d checked, %0d mismatches",
                 words_sent, sb.compared, sb.mismatches);
        $display("stall trips %0d, watchdog arms %0d, brakes %0d, input stall cycles %0d",
                 sb.limit_hits, sb.limit_clears, sb.brakes, stall_cycles);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
